@@ rtl/cvt_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cvt_pkg
// Shared constants for the calibrated value to temperature block.
// ----------------------------------------------------------------------------
package cvt_pkg;
   localparam int MAX_POINTS_DEFAULT = 32;
   localparam int VALUE_BITS_DEFAULT = 16;
   localparam int TEMP_BITS = 16;
   localparam int STATUS_BITS = 3;

   localparam logic [STATUS_BITS-1:0] ST_INTERP = 3'd0;
   localparam logic [STATUS_BITS-1:0] ST_LOW    = 3'd1;
   localparam logic [STATUS_BITS-1:0] ST_HIGH   = 3'd2;
   localparam logic [STATUS_BITS-1:0] ST_EMPTY  = 3'd3;
   localparam logic [STATUS_BITS-1:0] ST_FULL   = 3'd4;

   localparam logic REQ_CONVERT = 1'b0;
   localparam logic REQ_INSERT  = 1'b1;
endpackage
`default_nettype wire

@@ rtl/cvt_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cvt_req_if / cvt_rsp_if
// Valid/ready channels for request and response items.
// ----------------------------------------------------------------------------
interface cvt_req_if;
   logic        valid;
   logic        ready;
   logic        req_type;
   logic [15:0] raw_value;
   logic signed [15:0] point_temperature;
   modport source (output valid, req_type, raw_value, point_temperature, input ready);
   modport sink   (input valid, req_type, raw_value, point_temperature, output ready);
endinterface

interface cvt_rsp_if;
   logic        valid;
   logic        ready;
   logic signed [15:0] temperature;
   logic [2:0]  status;
   modport source (output valid, temperature, status, input ready);
   modport sink   (input valid, temperature, status, output ready);
endinterface
`default_nettype wire

@@ rtl/calibrated_value_to_temperature.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// calibrated_value_to_temperature
// Piecewise linear lookup from sensor reading to temperature.
// ----------------------------------------------------------------------------
// Channel  Port  Direction  Contents
// req      sink  in         req_type, raw_value, point_temperature
// rsp      src   out        temperature, status
//
// One item at a time. A convert item reads and scans the N points (one registered
// memory read per cycle), forms the numerator in S_MUL and S_FIX, then runs the
// restoring divider. Clamped and empty results come out early.
// An insert item scans entry by entry to its position and then shifts the tail
// up one entry at a time.
// Reset clears the point count; table entries are undefined until written.
// A stalled response holds its register; no new item is taken until it leaves.
// ----------------------------------------------------------------------------
module calibrated_value_to_temperature #(
   parameter int MAX_POINTS = cvt_pkg::MAX_POINTS_DEFAULT,
   parameter int VALUE_BITS = cvt_pkg::VALUE_BITS_DEFAULT
) (
   input  wire logic clock,
   input  wire logic reset,
   cvt_req_if.sink   req,
   cvt_rsp_if.source rsp
);
   localparam int IB = $clog2(MAX_POINTS);
   localparam int CB = $clog2(MAX_POINTS + 1);
   localparam int DB = VALUE_BITS + 1;          // den width
   localparam int NB = VALUE_BITS + 20;         // |num| width incl. sign room
   localparam int QB = NB;
   localparam int DCB = $clog2(QB + 1);

   typedef enum logic [9:0] {
      S_IDLE  = 10'b0000000001,
      S_RD    = 10'b0000000010,
      S_SCAN  = 10'b0000000100,
      S_SHIFT = 10'b0000001000,
      S_MUL   = 10'b0000010000,
      S_DIV   = 10'b0000100000,
      S_FIX   = 10'b0001000000,
      S_OUT   = 10'b0010000000,
      S_FIRST = 10'b0100000000,
      S_LAST  = 10'b1000000000
   } state_type;

   logic signed [15:0] mem_t [MAX_POINTS];
   logic [VALUE_BITS-1:0] mem_v [MAX_POINTS];

   state_type state_ff, state_in;
   logic [CB-1:0] count_ff, count_in;
   logic [CB-1:0] idx_ff, idx_in;
   logic op_ff, op_in;
   logic [VALUE_BITS-1:0] v_ff, v_in;
   logic signed [15:0] t_ff, t_in;
   // Registered read data.
   logic signed [15:0] rd_t_ff;
   logic [VALUE_BITS-1:0] rd_v_ff;
   logic signed [15:0] prv_t_ff, prv_t_in;
   logic [VALUE_BITS-1:0] prv_v_ff, prv_v_in;
   logic found_ff, found_in;
   logic signed [15:0] lo_t_ff, lo_t_in, hi_t_ff, hi_t_in, first_t_ff, first_t_in;
   logic [VALUE_BITS-1:0] lo_v_ff, lo_v_in, hi_v_ff, hi_v_in;
   logic [CB-1:0] pos_ff, pos_in;
   logic match_ff, match_in;
   logic [NB-1:0] rem_ff, rem_in, quo_ff, quo_in;
   logic [DB:0] dvs_ff, dvs_in;
   logic neg_ff, neg_in;
   logic [DCB-1:0] dcnt_ff, dcnt_in;
   logic signed [15:0] res_t_ff, res_t_in;
   logic [2:0] res_s_ff, res_s_in;
   logic rsp_v_ff, rsp_v_in;
   logic signed [NB-1:0] prod_ff, prod_in;

   logic [IB-1:0] rd_addr;
   logic wr_en;
   logic [IB-1:0] wr_addr;
   logic signed [15:0] wr_t;
   logic [VALUE_BITS-1:0] wr_v;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_t[wr_addr] <= wr_t;
         mem_v[wr_addr] <= wr_v;
      end
      rd_t_ff <= mem_t[rd_addr];
      rd_v_ff <= mem_v[rd_addr];
   end

   assign req.ready = (state_ff == S_IDLE) && !rsp_v_ff;
   assign rsp.valid = rsp_v_ff;
   assign rsp.temperature = res_t_ff;
   assign rsp.status = res_s_ff;

   logic [DB:0] den_w;
   logic [NB:0] trial;
   logic [IB:0] idx_m1;
   assign den_w  = {1'b0, {1'b0, hi_v_ff} - {1'b0, lo_v_ff}};
   assign trial  = {rem_ff, quo_ff[NB-1]} - {{(NB-DB){1'b0}}, dvs_ff};
   assign idx_m1 = {1'b0, idx_ff[IB-1:0]} - 1'b1;

   always_comb begin
      state_in = state_ff; count_in = count_ff; idx_in = idx_ff; op_in = op_ff;
      v_in = v_ff; t_in = t_ff; prv_t_in = prv_t_ff; prv_v_in = prv_v_ff;
      found_in = found_ff; lo_t_in = lo_t_ff; hi_t_in = hi_t_ff; lo_v_in = lo_v_ff;
      hi_v_in = hi_v_ff; first_t_in = first_t_ff; pos_in = pos_ff; match_in = match_ff;
      rem_in = rem_ff; quo_in = quo_ff; dvs_in = dvs_ff; neg_in = neg_ff;
      dcnt_in = dcnt_ff; res_t_in = res_t_ff; res_s_in = res_s_ff; prod_in = prod_ff;
      rsp_v_in = rsp_v_ff && !rsp.ready;
      rd_addr = idx_ff[IB-1:0]; wr_en = 1'b0; wr_addr = idx_ff[IB-1:0];
      wr_t = t_ff; wr_v = v_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req.valid && req.ready) begin
               op_in = req.req_type;
               v_in = VALUE_BITS'(req.raw_value);
               t_in = req.point_temperature;
               idx_in = '0; found_in = 1'b0; match_in = 1'b0;
               rd_addr = '0;
               if (req.req_type == cvt_pkg::REQ_CONVERT && count_ff == '0) begin
                  res_t_in = '0; res_s_in = cvt_pkg::ST_EMPTY; rsp_v_in = 1'b1;
               end else if (req.req_type == cvt_pkg::REQ_INSERT && count_ff == '0) begin
                  wr_en = 1'b1; wr_addr = '0;
                  wr_t = req.point_temperature; wr_v = VALUE_BITS'(req.raw_value);
                  count_in = CB'(1);
                  res_t_in = '0; res_s_in = cvt_pkg::ST_INTERP; rsp_v_in = 1'b1;
               end else begin
                  state_in = S_RD;
                  idx_in = CB'(1);
               end
            end
         end
         S_RD: begin
            // Entry 0 data arrives now.
            prv_t_in = rd_t_ff; prv_v_in = rd_v_ff; first_t_in = rd_t_ff;
            if (op_ff == cvt_pkg::REQ_CONVERT) begin
               if (v_ff < rd_v_ff) begin
                  res_t_in = rd_t_ff; res_s_in = cvt_pkg::ST_LOW;
                  rsp_v_in = 1'b1; state_in = S_IDLE;
               end else begin
                  rd_addr = IB'(count_ff - 1'b1);
                  state_in = S_LAST;
               end
            end else begin
               if (rd_t_ff >= t_ff) begin
                  pos_in = '0; match_in = (rd_t_ff == t_ff);
                  state_in = S_FIRST;
               end else if (idx_ff == count_ff) begin
                  pos_in = count_ff; state_in = S_FIRST;
               end else begin
                  state_in = S_SCAN;
               end
            end
            if (op_ff == cvt_pkg::REQ_INSERT && state_in == S_SCAN)
               rd_addr = idx_ff[IB-1:0];
         end
         S_LAST: begin
            // Keep the last point on the read port into S_FIRST.
            rd_addr = IB'(count_ff - 1'b1);
            state_in = S_FIRST;
         end
         S_FIRST: begin
            if (op_ff == cvt_pkg::REQ_CONVERT) begin
               // rd data holds the last point.
               if (v_ff > rd_v_ff) begin
                  res_t_in = rd_t_ff; res_s_in = cvt_pkg::ST_HIGH;
                  rsp_v_in = 1'b1; state_in = S_IDLE;
               end else if (count_ff == CB'(1)) begin
                  res_t_in = first_t_ff; res_s_in = cvt_pkg::ST_INTERP;
                  rsp_v_in = 1'b1; state_in = S_IDLE;
               end else begin
                  idx_in = CB'(2); rd_addr = IB'(1); state_in = S_SCAN;
               end
            end else begin
               if (match_ff) begin
                  wr_en = 1'b1; wr_addr = pos_ff[IB-1:0];
                  res_t_in = '0; res_s_in = cvt_pkg::ST_INTERP;
                  rsp_v_in = 1'b1; state_in = S_IDLE;
               end else if (count_ff >= CB'(MAX_POINTS)) begin
                  res_t_in = '0; res_s_in = cvt_pkg::ST_FULL;
                  rsp_v_in = 1'b1; state_in = S_IDLE;
               end else if (pos_ff == count_ff) begin
                  wr_en = 1'b1; wr_addr = pos_ff[IB-1:0];
                  count_in = count_ff + 1'b1;
                  res_t_in = '0; res_s_in = cvt_pkg::ST_INTERP;
                  rsp_v_in = 1'b1; state_in = S_IDLE;
               end else begin
                  idx_in = count_ff; rd_addr = IB'(count_ff - 1'b1);
                  state_in = S_SHIFT; match_in = 1'b1;
               end
            end
         end
         S_SCAN: begin
            if (op_ff == cvt_pkg::REQ_CONVERT) begin
               // rd data is entry idx-1 and prv holds entry idx-2.
               if (prv_v_ff <= v_ff && v_ff <= rd_v_ff) begin
                  hi_t_in = rd_t_ff;
                  if (!found_ff) begin
                     found_in = 1'b1; lo_t_in = prv_t_ff;
                     lo_v_in = prv_v_ff; hi_v_in = rd_v_ff;
                  end else begin
                     if (prv_v_ff < lo_v_ff) lo_v_in = prv_v_ff;
                     if (rd_v_ff > hi_v_ff) hi_v_in = rd_v_ff;
                  end
               end else if (prv_v_ff >= v_ff && v_ff >= rd_v_ff) begin
                  hi_t_in = rd_t_ff;
                  if (!found_ff) begin
                     found_in = 1'b1; lo_t_in = prv_t_ff;
                     lo_v_in = rd_v_ff; hi_v_in = prv_v_ff;
                  end else begin
                     if (prv_v_ff > hi_v_ff) hi_v_in = prv_v_ff;
                     if (rd_v_ff < lo_v_ff) lo_v_in = rd_v_ff;
                  end
               end
               prv_t_in = rd_t_ff; prv_v_in = rd_v_ff;
               if (idx_ff == count_ff) begin
                  state_in = S_MUL;
               end else begin
                  idx_in = idx_ff + 1'b1;
                  rd_addr = idx_ff[IB-1:0];
               end
            end else begin
               // Insert position search; rd data is entry idx, with a wait state between entries.
               if (match_ff) begin
                  match_in = 1'b0; rd_addr = idx_ff[IB-1:0];
               end else if (rd_t_ff >= t_ff) begin
                  pos_in = idx_ff; match_in = (rd_t_ff == t_ff); state_in = S_FIRST;
               end else if (idx_ff + 1'b1 == count_ff) begin
                  pos_in = count_ff; match_in = 1'b0; state_in = S_FIRST;
               end else begin
                  idx_in = idx_ff + 1'b1; rd_addr = IB'(idx_ff + 1'b1); match_in = 1'b1;
               end
            end
         end
         S_SHIFT: begin
            // Move entry idx-1 to idx, with a wait state between entries.
            if (match_ff) begin
               match_in = 1'b0; rd_addr = idx_m1[IB-1:0];
            end else begin
               wr_en = 1'b1; wr_addr = idx_ff[IB-1:0];
               wr_t = rd_t_ff; wr_v = rd_v_ff;
               if (idx_m1[IB-1:0] == pos_ff[IB-1:0]) begin
                  // The new point is written at pos on the way back through S_FIRST.
                  state_in = S_FIRST; match_in = 1'b1;
                  count_in = count_ff + 1'b1;
               end else begin
                  idx_in = CB'(idx_m1); rd_addr = IB'(idx_m1 - 1'b1); match_in = 1'b1;
               end
            end
         end
         S_MUL: begin
            if (!found_ff) begin
               res_t_in = first_t_ff; res_s_in = cvt_pkg::ST_INTERP;
               rsp_v_in = 1'b1; state_in = S_IDLE;
            end else if (den_w == '0) begin
               res_t_in = lo_t_ff; res_s_in = cvt_pkg::ST_INTERP;
               rsp_v_in = 1'b1; state_in = S_IDLE;
            end else begin
               prod_in = NB'($signed({1'b0, v_ff - lo_v_ff}) *
                             ($signed({hi_t_ff[15], hi_t_ff}) - $signed({lo_t_ff[15], lo_t_ff})));
               state_in = S_FIX;
            end
         end
         S_FIX: begin
            // num = den*(2*lo_t + 1) + 2*prod ; divide by 2*den.
            prod_in = NB'($signed({1'b0, den_w}) * ($signed({lo_t_ff, 1'b1})))
                      + (prod_ff <<< 1);
            neg_in = 1'b0;
            dvs_in = {den_w[DB-1:0], 1'b0};
            rem_in = '0; dcnt_in = DCB'(QB);
            state_in = S_DIV; match_in = 1'b1;
         end
         S_DIV: begin
            if (match_ff) begin
               match_in = 1'b0;
               neg_in = prod_ff[NB-1];
               quo_in = prod_ff[NB-1] ? NB'(-prod_ff) : NB'(prod_ff);
            end else if (dcnt_ff == '0) begin
               res_t_in = neg_ff ? 16'(-quo_ff) : 16'(quo_ff);
               res_s_in = cvt_pkg::ST_INTERP; rsp_v_in = 1'b1; state_in = S_IDLE;
            end else begin
               if (!trial[NB]) begin
                  rem_in = trial[NB-1:0]; quo_in = {quo_ff[NB-2:0], 1'b1};
               end else begin
                  rem_in = {rem_ff[NB-2:0], quo_ff[NB-1]}; quo_in = {quo_ff[NB-2:0], 1'b0};
               end
               dcnt_in = dcnt_ff - 1'b1;
            end
         end
         S_OUT: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; count_ff <= '0; rsp_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in; count_ff <= count_in; rsp_v_ff <= rsp_v_in;
      end
      idx_ff <= idx_in; op_ff <= op_in; v_ff <= v_in; t_ff <= t_in;
      prv_t_ff <= prv_t_in; prv_v_ff <= prv_v_in; found_ff <= found_in;
      lo_t_ff <= lo_t_in; hi_t_ff <= hi_t_in; lo_v_ff <= lo_v_in; hi_v_ff <= hi_v_in;
      first_t_ff <= first_t_in; pos_ff <= pos_in; match_ff <= match_in;
      rem_ff <= rem_in; quo_ff <= quo_in; dvs_ff <= dvs_in; neg_ff <= neg_in;
      dcnt_ff <= dcnt_in; res_t_ff <= res_t_in; res_s_ff <= res_s_in; prod_ff <= prod_in;
   end
endmodule
`default_nettype wire

@@ rtl/cvt_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cvt_checker
// Port-level checks for the converter.
// ----------------------------------------------------------------------------
module cvt_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_ready,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic [2:0] rsp_status,
   input wire logic [15:0] rsp_temperature
);
   // No new item is taken while a response waits.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("ready while response pending");
   // Status codes stay in range.
   a_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= cvt_pkg::ST_FULL) else $error("bad status");
   // Empty and dropped results carry zero temperature.
   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == cvt_pkg::ST_EMPTY || rsp_status == cvt_pkg::ST_FULL)
      |-> rsp_temperature == 16'd0)
      else $error("nonzero temperature");
   // A stalled response stays valid and holds its status.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
      else $error("response dropped");
endmodule

bind calibrated_value_to_temperature cvt_checker u_cvt_checker (
   .clock(clock), .reset(reset),
   .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_status(rsp.status), .rsp_temperature(rsp.temperature)
);
`default_nettype wire

@@ test/tb_calibrated_value_to_temperature.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_calibrated_value_to_temperature
// Fills and probes the calibration table with insert and convert items under
// random source and sink gaps, and checks every result against a behavioral
// table and interpolation model kept inside the bench.
// ----------------------------------------------------------------------------
module tb_calibrated_value_to_temperature;

   typedef struct packed {
      logic               kind;
      logic [15:0]        raw;
      logic signed [15:0] temp;
   } cal_item_type;

   typedef struct packed {
      logic signed [15:0] temp;
      logic [2:0]         status;
   } cal_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   cvt_req_if req ();
   cvt_rsp_if rsp ();

   calibrated_value_to_temperature dut (
      .clock (clock),
      .reset (reset),
      .req   (req.sink),
      .rsp   (rsp.source)
   );

   // Bench copy of the calibration table.
   int          tbl_temp [cvt_pkg::MAX_POINTS_DEFAULT];
   int unsigned tbl_read [cvt_pkg::MAX_POINTS_DEFAULT];
   int unsigned tbl_count = 0;

   cal_item_type   pending_items [$];
   cal_result_type expected_results [$];
   int          errors = 0;
   int          n_conv = 0;
   int          n_ins = 0;
   int          n_status [5];
   bit          quiet_phase = 1'b0;
   bit          driver_hold = 1'b0;
   int          sink_hold = 0;

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic cal_result_type table_apply(cal_item_type it);
      cal_result_type r;
      int unsigned pos;
      int          t;
      int unsigned v;
      bit          found;
      int          lo_t;
      int          hi_t;
      int unsigned lo_v;
      int unsigned hi_v;
      int unsigned a;
      int unsigned b;
      longint      den;
      longint      num;
      r.temp = '0;
      r.status = cvt_pkg::ST_INTERP;
      v = it.raw;
      if (it.kind == cvt_pkg::REQ_INSERT) begin
         t = it.temp;
         pos = 0;
         while (pos < tbl_count && tbl_temp[pos] < t) pos++;
         if (pos < tbl_count && tbl_temp[pos] == t) begin
            tbl_read[pos] = v;
         end else if (tbl_count >= cvt_pkg::MAX_POINTS_DEFAULT) begin
            r.status = cvt_pkg::ST_FULL;
         end else begin
            for (int k = tbl_count; k > pos; k--) begin
               tbl_temp[k] = tbl_temp[k-1];
               tbl_read[k] = tbl_read[k-1];
            end
            tbl_temp[pos] = t;
            tbl_read[pos] = v;
            tbl_count++;
         end
         return r;
      end
      if (tbl_count == 0) begin
         r.status = cvt_pkg::ST_EMPTY;
         return r;
      end
      if (v < tbl_read[0]) begin
         r.temp = 16'(tbl_temp[0]);
         r.status = cvt_pkg::ST_LOW;
         return r;
      end
      if (v > tbl_read[tbl_count-1]) begin
         r.temp = 16'(tbl_temp[tbl_count-1]);
         r.status = cvt_pkg::ST_HIGH;
         return r;
      end
      found = 1'b0;
      lo_t = 0;
      hi_t = 0;
      lo_v = 0;
      hi_v = 0;
      for (int k = 1; k < tbl_count; k++) begin
         a = tbl_read[k-1];
         b = tbl_read[k];
         if (a <= v && v <= b) begin
            hi_t = tbl_temp[k];
            if (!found) begin
               found = 1'b1;
               lo_t = tbl_temp[k-1];
               lo_v = a;
               hi_v = b;
            end else begin
               if (a < lo_v) lo_v = a;
               if (b > hi_v) hi_v = b;
            end
         end else if (a >= v && v >= b) begin
            hi_t = tbl_temp[k];
            if (!found) begin
               found = 1'b1;
               lo_t = tbl_temp[k-1];
               lo_v = b;
               hi_v = a;
            end else begin
               if (a > hi_v) hi_v = a;
               if (b < lo_v) lo_v = b;
            end
         end
      end
      if (!found) begin
         r.temp = 16'(tbl_temp[0]);
         return r;
      end
      den = longint'(hi_v) - longint'(lo_v);
      if (den <= 0) begin
         r.temp = 16'(lo_t);
         return r;
      end
      num = 2 * longint'(lo_t) * den + den
            + 2 * (longint'(v) - longint'(lo_v)) * (longint'(hi_t) - longint'(lo_t));
      r.temp = 16'(num / (2 * den));
      return r;
   endfunction

   function automatic cal_item_type make_item(logic kind, int unsigned raw, int temp);
      cal_item_type it;
      it.kind = kind;
      it.raw = 16'(raw);
      it.temp = 16'(temp);
      return it;
   endfunction

   function automatic bit gap_roll();
      return !quiet_phase && ($urandom_range(99) < 14);
   endfunction

   // Driver: one item per handshake, random gaps between items.
   always @(posedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
      end else if (!req.valid || req.ready) begin
         if (req.valid && req.ready) begin
            expected_results.push_back(table_apply({req.req_type, req.raw_value,
                                                    req.point_temperature}));
            if (req.req_type == cvt_pkg::REQ_INSERT) n_ins++;
            else n_conv++;
         end
         if (pending_items.size() > 0 && !driver_hold && !gap_roll()) begin
            req.valid <= 1'b1;
            req.req_type <= pending_items[0].kind;
            req.raw_value <= pending_items[0].raw;
            req.point_temperature <= pending_items[0].temp;
            void'(pending_items.pop_front());
         end else begin
            req.valid <= 1'b0;
         end
      end
   end

   // Monitor and sink: compares each result with the oldest expectation.
   always @(posedge clock) begin
      cal_result_type e;
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (expected_results.size() == 0) begin
               $error("result with nothing expected: temperature %0d status %0d",
                      rsp.temperature, rsp.status);
               errors++;
            end else begin
               e = expected_results.pop_front();
               if (rsp.temperature !== e.temp) begin
                  $error("temperature: expected %0d, got %0d", e.temp, rsp.temperature);
                  errors++;
               end
               if (rsp.status !== e.status) begin
                  $error("status: expected %0d, got %0d", e.status, rsp.status);
                  errors++;
               end
               if (e.status <= cvt_pkg::ST_FULL) n_status[e.status]++;
            end
         end
         if (sink_hold > 0) begin
            sink_hold <= sink_hold - 1;
            rsp.ready <= 1'b0;
         end else begin
            rsp.ready <= !gap_roll();
         end
      end
   end

   task automatic wait_drained();
      while (pending_items.size() > 0 || req.valid || expected_results.size() > 0)
         @(posedge clock);
   endtask

   task automatic add_random_table(int points);
      int unsigned base;
      base = $urandom_range(40000);
      for (int i = 0; i < points; i++) begin
         if ($urandom_range(3) == 0)
            pending_items.push_back(make_item(cvt_pkg::REQ_INSERT, $urandom, $urandom));
         else
            pending_items.push_back(make_item(cvt_pkg::REQ_INSERT,
               base + i * $urandom_range(800) + $urandom_range(50),
               $urandom_range(400) - 200 + i * 37));
      end
   endtask

   initial begin
      int unsigned v;
      req.valid = 1'b0;
      req.req_type = cvt_pkg::REQ_CONVERT;
      req.raw_value = '0;
      req.point_temperature = '0;
      rsp.ready = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty table, single point, clamps, equal bounds, extremes.
      pending_items.push_back(make_item(cvt_pkg::REQ_CONVERT, 16'hFFFF, 0));
      pending_items.push_back(make_item(cvt_pkg::REQ_INSERT, 1000, 100));
      pending_items.push_back(make_item(cvt_pkg::REQ_CONVERT, 1000, 0));
      pending_items.push_back(make_item(cvt_pkg::REQ_CONVERT, 999, 0));
      pending_items.push_back(make_item(cvt_pkg::REQ_CONVERT, 1001, 0));
      pending_items.push_back(make_item(cvt_pkg::REQ_INSERT, 3000, -32768));
      pending_items.push_back(make_item(cvt_pkg::REQ_INSERT, 0, 32767));
      pending_items.push_back(make_item(cvt_pkg::REQ_INSERT, 65535, 200));
      pending_items.push_back(make_item(cvt_pkg::REQ_CONVERT, 0, 0));
      pending_items.push_back(make_item(cvt_pkg::REQ_CONVERT, 3000, 16'h5555));
      pending_items.push_back(make_item(cvt_pkg::REQ_CONVERT, 2000, 0));
      pending_items.push_back(make_item(cvt_pkg::REQ_CONVERT, 65535, 0));
      pending_items.push_back(make_item(cvt_pkg::REQ_INSERT, 65535, 100));
      pending_items.push_back(make_item(cvt_pkg::REQ_CONVERT, 65535, 0));
      pending_items.push_back(make_item(cvt_pkg::REQ_CONVERT, 40000, 0));
      wait_drained();

      // Fill the table to capacity, then try a new temperature and an overwrite.
      for (int i = 0; i < cvt_pkg::MAX_POINTS_DEFAULT; i++)
         pending_items.push_back(make_item(cvt_pkg::REQ_INSERT, 2000 + i * 1500,
                                           i * 50 - 800));
      pending_items.push_back(make_item(cvt_pkg::REQ_INSERT, 1234, 31000));
      pending_items.push_back(make_item(cvt_pkg::REQ_INSERT, 4000, -800));
      pending_items.push_back(make_item(cvt_pkg::REQ_CONVERT, 2500, 0));
      pending_items.push_back(make_item(cvt_pkg::REQ_CONVERT, 50000, 0));
      // Sink holds off for a long stretch while items keep coming.
      sink_hold = 400;
      for (int i = 0; i < 300; i++) begin
         v = ($urandom_range(9) == 0) ? $urandom : 2000 + $urandom_range(46500);
         pending_items.push_back(make_item(cvt_pkg::REQ_CONVERT, v, $urandom));
      end
      wait_drained();

      // Random phase: the table shape cannot be cleared, so growth is bounded
      // by capacity; overwrites keep changing readings, including noise.
      quiet_phase = 1'b1;
      for (int i = 0; i < 200; i++) begin
         if ($urandom_range(4) == 0)
            pending_items.push_back(make_item(cvt_pkg::REQ_INSERT, $urandom,
               (i * 50 - 800) % 1600));
         else
            pending_items.push_back(make_item(cvt_pkg::REQ_CONVERT, $urandom, $urandom));
      end
      wait_drained();
      quiet_phase = 1'b0;
      add_random_table(8);
      for (int i = 0; i < 850; i++) begin
         case ($urandom_range(9))
            0: pending_items.push_back(make_item(cvt_pkg::REQ_INSERT, $urandom, $urandom));
            1: pending_items.push_back(make_item(cvt_pkg::REQ_INSERT, $urandom,
                  $urandom_range(1600) - 800));
            default: pending_items.push_back(make_item(cvt_pkg::REQ_CONVERT,
                  ($urandom_range(5) == 0) ? $urandom : 2000 + $urandom_range(48000),
                  $urandom));
         endcase
         if (i == 400) begin
            wait_drained();
            // Everything has come back; the sender is then held idle before the next items.
            driver_hold = 1'b1;
            repeat (50) @(posedge clock);
            driver_hold = 1'b0;
         end
      end
      wait_drained();
      repeat (200) @(posedge clock);

      $display("Ran %0d converts and %0d inserts; status counts interp %0d low %0d",
               n_conv, n_ins, n_status[0], n_status[1]);
      $display("high %0d empty %0d full %0d", n_status[2], n_status[3], n_status[4]);
      if (errors == 0 && expected_results.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("[FAIL] regression broken");
      $finish;
   end
endmodule

@@ calibrated_value_to_temperature.f @@
rtl/cvt_pkg.sv
rtl/cvt_if.sv
rtl/calibrated_value_to_temperature.sv
rtl/cvt_checker.sv
test/tb_calibrated_value_to_temperature.sv
